@@ rtl/alm_pkg.sv @@
package alm_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_CHK,
		ST_PSQ,
		ST_NORM,
		ST_FRAC,
		ST_DB,
		ST_WR,
		ST_OUT
	} alm_state_t;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// accumulator and level formats
	localparam int                    SUM_W    = 62;
	localparam logic [SUM_W-1:0]      SUM_CAP  = '1;
	localparam int                    LVL_W    = 15;
	localparam logic signed [LVL_W-1:0] FLOOR_DB = -15'sd15360;
	localparam logic [13:0]           FLOOR_MAG = 14'd15360;

	// 10*log10(2)*256 in Q16
	localparam logic [25:0] DB_COEF = 26'd50504453;

	// log2 unit formats
	localparam int                LOG_W      = 22;
	localparam int                D_W        = 24;
	localparam int                DMAG_W     = 23;
	localparam logic [3:0]        NORM_LAST  = 4'd5;
	localparam logic [3:0]        FRAC_LAST  = 4'd15;

	// meter numbering
	localparam logic [2:0] LAST_METER = 3'd7;

endpackage

@@ rtl/audio_level_meter_db_unit.sv @@
// Six-channel audio level meter. A sample item (req_type 0) adds its square to the channel's
// sum, bumps the channel's count and tracks its peak magnitude while the count is below
// MAX_WINDOW; it is accepted, squared on the shared 32x32 multiplier, then accumulated, and
// in_ready is low while it squares and accumulates. A tick item (req_type 1) turns every
// channel into a level in 1/256 dB, RMS or peak as set by peak_mode, then sends eight results
// (meters 0-5, then 4 minus 0 and 5 minus 1, last on meter 7) and clears the accumulators.
// The tick runs on one shared multiplier under a small sequencer: each log2 takes 6 normalize
// steps and 16 squaring steps, and a channel with samples takes two logs (power and count,
// the count being 1 in peak mode); one with no samples is passed over. The eight results
// then follow at one per cycle while out_ready is high. A channel with no samples keeps its
// previous level; levels are clamped to -60 dB. peak_mode is written through the cfg
// channel, which is always ready, and should only change while the block is idle.
module audio_level_meter_db_unit #(
	parameter int CHANNELS    = 6,
	parameter int MAX_WINDOW  = 65536,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 peak_mode,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 req_type,
	input  logic [2:0]                           channel,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [2:0]                           meter_index,
	output logic signed [alm_pkg::LVL_W-1:0]     level_db,
	output logic                                 last
);

	import alm_pkg::*;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam logic [CH_W-1:0]         LAST_CH   = CH_W'(CHANNELS - 1);
	localparam logic [CNT_W-1:0]        CNT_MAX   = CNT_W'(MAX_WINDOW);
	localparam logic signed [D_W-1:0]   FS_OFFSET = D_W'((2 * SAMPLE_BITS - 2) * 65536);

	alm_state_t state_q, state_d;

	logic                   peak_mode_q;
	logic [CH_W-1:0]        ch_q;
	logic [CH_W-1:0]        c_q;
	logic [2:0]             k_q;
	logic [3:0]             step_q;
	logic                   lsel_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [63:0]            prod_q;
	logic [63:0]            x_q;
	logic [5:0]             s_q;
	logic [31:0]            m_q;
	logic [15:0]            frac_q;
	logic [LOG_W-1:0]       lp_q;
	logic signed [D_W-1:0]  d_q;
	logic                   out_valid_q;
	logic [2:0]             meter_index_q;
	logic signed [LVL_W-1:0] level_q;
	logic                   last_q;

	// per-channel accumulators and held levels
	logic [SUM_W-1:0]        sum_q  [CHANNELS];
	logic [CNT_W-1:0]        cnt_q  [CHANNELS];
	logic [SAMPLE_BITS-1:0]  peak_q [CHANNELS];
	logic signed [LVL_W-1:0] prev_q [CHANNELS];

	logic                    accept;
	logic                    ch_ok;
	logic                    chan_adv;
	logic                    out_load;
	logic [SAMPLE_BITS-1:0]  mag_in;
	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             mul_p;
	logic [64:0]             sum_add;
	logic [SUM_W-1:0]        sum_sat;
	logic [63:0]             x_norm;
	logic [5:0]              s_norm;
	logic                    fbit;
	logic [31:0]             m_next;
	logic [15:0]             frac_next;
	logic [LOG_W-1:0]        log_res;
	logic signed [D_W-1:0]   d_calc;
	logic [DMAG_W-1:0]       dmag;
	logic [49:0]             rnd;
	logic [17:0]             q_db;
	logic signed [LVL_W-1:0] lvl_new;
	logic signed [LVL_W-1:0] lvl_m [6];
	logic signed [LVL_W-1:0] lvl_sel;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign ch_ok       = (32'(channel) < 32'(CHANNELS));
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign meter_index = meter_index_q;
	assign level_db    = level_q;
	assign last        = last_q;

	// sample magnitude, most negative value maps to 2^(n-1)
	assign mag_in = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ: begin
				mul_a = 32'(mag_q);
				mul_b = 32'(mag_q);
			end
			ST_PSQ: begin
				mul_a = 32'(peak_q[c_q]);
				mul_b = 32'(peak_q[c_q]);
			end
			ST_FRAC: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			ST_DB: begin
				mul_a = 32'(dmag);
				mul_b = 32'(DB_COEF);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// saturating sum of squares
	assign sum_add = {3'b000, sum_q[ch_q]} + {1'b0, prod_q};
	assign sum_sat = (sum_add > {3'b000, SUM_CAP}) ? SUM_CAP : sum_add[SUM_W-1:0];

	// one binary normalize step: shift out leading zeros
	always_comb begin
		x_norm = x_q;
		s_norm = s_q;
		case (step_q[2:0])
			3'd0: if (x_q[63:32] == '0) begin
				x_norm = {x_q[31:0], 32'b0};
				s_norm = s_q | 6'd32;
			end
			3'd1: if (x_q[63:48] == '0) begin
				x_norm = {x_q[47:0], 16'b0};
				s_norm = s_q | 6'd16;
			end
			3'd2: if (x_q[63:56] == '0) begin
				x_norm = {x_q[55:0], 8'b0};
				s_norm = s_q | 6'd8;
			end
			3'd3: if (x_q[63:60] == '0) begin
				x_norm = {x_q[59:0], 4'b0};
				s_norm = s_q | 6'd4;
			end
			3'd4: if (x_q[63:62] == '0) begin
				x_norm = {x_q[61:0], 2'b0};
				s_norm = s_q | 6'd2;
			end
			3'd5: if (!x_q[63]) begin
				x_norm = {x_q[62:0], 1'b0};
				s_norm = s_q | 6'd1;
			end
			default: begin
				x_norm = x_q;
				s_norm = s_q;
			end
		endcase
	end

	// one fraction bit per squaring of the mantissa
	assign fbit      = mul_p[63];
	assign m_next    = fbit ? mul_p[63:32] : mul_p[62:31];
	assign frac_next = {frac_q[14:0], fbit};
	assign log_res   = {~s_q, frac_next};

	// log difference against full scale
	assign d_calc = $signed({2'b00, lp_q}) - $signed({2'b00, log_res}) - FS_OFFSET;
	assign dmag   = DMAG_W'(-d_q);

	// scale to 1/256 dB with rounding, clamp at the floor
	assign rnd     = {1'b0, prod_q[48:0]} + 50'h0_0000_8000_0000;
	assign q_db    = rnd[49:32];
	assign lvl_new = (q_db >= 18'(FLOOR_MAG)) ? FLOOR_DB : -$signed({1'b0, q_db[13:0]});

	// meter levels, missing channels sit at the floor
	for (genvar g = 0; g < 6; g++) begin : g_lvl
		if (g < CHANNELS) begin : g_ch
			assign lvl_m[g] = prev_q[g];
		end else begin : g_none
			assign lvl_m[g] = FLOOR_DB;
		end
	end

	always_comb begin
		case (k_q)
			3'd0:    lvl_sel = lvl_m[0];
			3'd1:    lvl_sel = lvl_m[1];
			3'd2:    lvl_sel = lvl_m[2];
			3'd3:    lvl_sel = lvl_m[3];
			3'd4:    lvl_sel = lvl_m[4];
			3'd5:    lvl_sel = lvl_m[5];
			3'd6:    lvl_sel = lvl_m[4] - lvl_m[0];
			default: lvl_sel = lvl_m[5] - lvl_m[1];
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d  = state_q;
		chan_adv = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_TICK) begin
						state_d = ST_CHK;
					end else if (ch_ok) begin
						state_d = ST_SQ;
					end
				end
			end
			ST_SQ:  state_d = ST_ACC;
			ST_ACC: state_d = ST_IDLE;
			ST_CHK: begin
				if (cnt_q[c_q] == '0) begin
					chan_adv = 1'b1;
				end else if (peak_mode_q) begin
					state_d = ST_PSQ;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_PSQ: state_d = ST_NORM;
			ST_NORM: begin
				if (step_q == '0 && x_q == '0) begin
					chan_adv = 1'b1;
				end else if (step_q == NORM_LAST) begin
					state_d = ST_FRAC;
				end
			end
			ST_FRAC: begin
				if (step_q == FRAC_LAST) begin
					state_d = lsel_q ? ST_DB : ST_NORM;
				end
			end
			ST_DB: begin
				if (d_q >= 0) begin
					chan_adv = 1'b1;
				end else begin
					state_d = ST_WR;
				end
			end
			ST_WR: chan_adv = 1'b1;
			ST_OUT: begin
				if (out_load && k_q == LAST_METER) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (chan_adv) begin
			state_d = (c_q == LAST_CH) ? ST_OUT : ST_CHK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_mode_q <= 1'b0;
			c_q         <= '0;
			k_q         <= '0;
			step_q      <= '0;
			lsel_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]  <= '0;
				cnt_q[i]  <= '0;
				peak_q[i] <= '0;
				prev_q[i] <= FLOOR_DB;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				peak_mode_q <= peak_mode;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						c_q <= '0;
					end
				end
				ST_ACC: begin
					if (cnt_q[ch_q] != CNT_MAX) begin
						sum_q[ch_q] <= sum_sat;
						cnt_q[ch_q] <= cnt_q[ch_q] + CNT_W'(1);
						if (mag_q > peak_q[ch_q]) begin
							peak_q[ch_q] <= mag_q;
						end
					end
				end
				ST_CHK: begin
					step_q <= '0;
					lsel_q <= 1'b0;
				end
				ST_NORM: begin
					step_q <= (step_q == NORM_LAST) ? '0 : step_q + 4'd1;
					if (step_q == '0 && x_q == '0) begin
						prev_q[c_q] <= FLOOR_DB;
					end
				end
				ST_FRAC: begin
					step_q <= step_q + 4'd1;
					if (step_q == FRAC_LAST) begin
						lsel_q <= 1'b1;
					end
				end
				ST_DB: begin
					if (d_q >= 0) begin
						prev_q[c_q] <= '0;
					end
				end
				ST_WR: prev_q[c_q] <= lvl_new;
				ST_OUT: begin
					if (out_load) begin
						k_q <= k_q + 3'd1;
					end
				end
				default: ;
			endcase
			// advance to next channel, or close the window
			if (chan_adv) begin
				if (c_q == LAST_CH) begin
					k_q <= '0;
					for (int i = 0; i < CHANNELS; i++) begin
						sum_q[i]  <= '0;
						cnt_q[i]  <= '0;
						peak_q[i] <= '0;
					end
				end else begin
					c_q <= c_q + CH_W'(1);
				end
			end
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mag_q <= mag_in;
					ch_q  <= CH_W'(channel);
				end
			end
			ST_SQ: prod_q <= mul_p;
			ST_CHK: begin
				x_q <= 64'(sum_q[c_q]);
				s_q <= '0;
			end
			ST_PSQ: x_q <= mul_p;
			ST_NORM: begin
				x_q <= x_norm;
				s_q <= s_norm;
				if (step_q == NORM_LAST) begin
					m_q    <= x_norm[63:32];
					frac_q <= '0;
				end
			end
			ST_FRAC: begin
				m_q    <= m_next;
				frac_q <= frac_next;
				if (step_q == FRAC_LAST) begin
					if (!lsel_q) begin
						lp_q <= log_res;
						x_q  <= peak_mode_q ? 64'd1 : 64'(cnt_q[c_q]);
						s_q  <= '0;
					end else begin
						d_q <= d_calc;
					end
				end
			end
			ST_DB: prod_q <= mul_p;
			ST_OUT: begin
				if (out_load) begin
					meter_index_q <= k_q;
					level_q       <= lvl_sel;
					last_q        <= (k_q == LAST_METER);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_SAMPLE && ch_ok |=> !in_ready)
		else $error("block ready right after taking a sample item");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> meter_index == LAST_METER)
		else $error("last flag on a meter other than the final one");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && meter_index < 3'd6 |-> level_db <= 15'sd0 && level_db >= FLOOR_DB)
		else $error("channel level outside the meter range");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] <= CNT_MAX)
		else $error("sample count beyond the window size");
`endif

endmodule
